// File: design/tfpd_pkg.sv
// Shared types, constants and the tracking error table of the tape follower steering block.
package tfpd_pkg;

  localparam int SAMPLE_BITS_DEF    = 10;
  localparam int DUTY_MAX_DEF       = 65535;
  localparam int RUN_COUNT_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int GAIN_W     = 10;
  localparam int THR_W      = 10;
  localparam int NOM_W      = 16;
  localparam int CLR_W      = 8;
  localparam int LOST_W     = 4;
  localparam int ERR_W      = 5;
  localparam int DE_W       = 6;
  localparam int DUTY_W     = 17;
  localparam int OUT_W      = 40;

  localparam int G_W   = 24;
  localparam int DVD_W = 25;
  localparam int SUM_W = 26;

  localparam int SLOW_DEN = 5;

  localparam logic [CFG_IDX_W-1:0] REG_P_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_D_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAPE_THR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BAR_THR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NOM_LEFT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NOM_RIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_RUN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_ERR  = 3'd7;

  typedef enum logic [1:0] {
    POS_OFF = 2'd0,
    POS_ON  = 2'd1,
    POS_BAR = 2'd2
  } pos_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_P,
    S_MUL_D,
    S_DIV1,
    S_DIV1_W,
    S_SUM,
    S_DIV2,
    S_DIV2_W,
    S_DUTY,
    S_OUT
  } st_t;

  function automatic logic signed [ERR_W-1:0] table_error(
    input pos_t                     cl,
    input pos_t                     cr,
    input pos_t                     pl,
    input pos_t                     pr,
    input logic signed [ERR_W-1:0]  last_err,
    input logic                     last_vld,
    input logic [LOST_W-1:0]        lost
  );
    logic                    prev_neg;
    logic                    prev_pos;
    logic signed [ERR_W-1:0] lost_s;
    logic signed [ERR_W-1:0] res;
    prev_neg = last_vld && (last_err < 0);
    prev_pos = !last_vld || (last_err > 0);
    lost_s   = $signed({1'b0, lost});
    res      = last_err;
    if (cl == POS_ON && cr == POS_ON) begin
      if (pl == POS_ON && pr == POS_ON) res = 5'sd0;
      else if (pl == POS_OFF && pr == POS_ON) res = -5'sd2;
      else if (pl == POS_ON && pr == POS_OFF) res = 5'sd2;
      else if (pl == POS_OFF && pr == POS_OFF) begin
        if (prev_pos) res = 5'sd1;
        else if (prev_neg) res = -5'sd1;
      end
    end else if (cl == POS_OFF && cr == POS_ON) begin
      if (pl == POS_ON && pr == POS_ON) res = -5'sd2;
      else if (pl == POS_OFF && pr == POS_ON) res = -5'sd3;
      else if (pl == POS_OFF && pr == POS_OFF) res = -5'sd4;
    end else if (cl == POS_ON && cr == POS_OFF) begin
      if (pl == POS_ON && pr == POS_ON) res = 5'sd2;
      else if (pl == POS_ON && pr == POS_OFF) res = 5'sd3;
      else if (pl == POS_OFF && pr == POS_OFF) res = 5'sd4;
    end else if (cl == POS_OFF && cr == POS_OFF) begin
      if (pl == POS_OFF && pr == POS_ON) res = -5'sd5;
      else if (pl == POS_ON && pr == POS_OFF) res = 5'sd5;
      else if (pl == POS_OFF && pr == POS_OFF) res = prev_neg ? -lost_s : lost_s;
    end
    return res;
  endfunction

endpackage

// File: design/tape_follow_pd_steering.sv
// Top level of the two-sensor PD tape follower that turns sensor samples into wheel duties.
// One input transfer is taken when the block is idle and yields one result transfer. A sample
// pair where both sensors read the bar goes straight to the output state. Otherwise the
// error, gain products and the derivative slope are worked out by a small sequencer around
// one shared restoring divider of 25 steps, used once for the derivative over the run length
// and once for the 6/5 scaling of the slowed wheel; the first use is skipped when no
// derivative applies. Configuration writes are taken at any time and should be made while idle.
module tape_follow_pd_steering
  import tfpd_pkg::*;
#(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int DUTY_MAX       = DUTY_MAX_DEF,
  parameter int RUN_COUNT_BITS = RUN_COUNT_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // Fields from bit 0 up: left_sample, right_sample, zero fill.
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       in_tdata,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // Fields from bit 0 up: steer_error, left_duty, right_duty, zero fill.
  output logic [OUT_W-1:0]                         out_tdata,
  // Fields from bit 0 up: at_bar.
  output logic                                     out_tuser,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]                     cfg_index,
  input  logic [CFG_DATA_W-1:0]                    cfg_data
);

  localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
  localparam int DEN_W = RUN_COUNT_BITS + 1;

  logic [GAIN_W-1:0] p_gain_r;
  logic [GAIN_W-1:0] d_gain_r;
  logic [THR_W-1:0]  tape_thr_r;
  logic [THR_W-1:0]  bar_thr_r;
  logic [NOM_W-1:0]  nom_left_r;
  logic [NOM_W-1:0]  nom_right_r;
  logic [CLR_W-1:0]  clear_run_r;
  logic [LOST_W-1:0] lost_err_r;

  pos_t                      last_lpos_r;
  pos_t                      last_rpos_r;
  logic signed [ERR_W-1:0]   last_err_r;
  logic                      last_vld_r;
  logic [RUN_COUNT_BITS-1:0] run_len_r;
  logic [RUN_COUNT_BITS-1:0] prior_len_r;
  logic                      prior_vld_r;
  logic signed [ERR_W-1:0]   prior_err_r;
  logic signed [DUTY_W-1:0]  held_left_r;
  logic signed [DUTY_W-1:0]  held_right_r;

  st_t                     st_r;
  st_t                     st_nxt;
  logic                    bar_r;
  logic signed [ERR_W-1:0] err_r;
  logic signed [DE_W-1:0]  de_r;
  logic                    use_d_r;
  logic [DEN_W-1:0]        den_r;
  logic signed [G_W-1:0]   a_r;
  logic [DVD_W-1:0]        bmag_r;
  logic                    b_neg_r;
  logic [G_W-1:0]          gmag_r;
  logic                    g_neg_r;

  logic                     out_tvalid_r;
  logic                     out_bar_r;
  logic signed [ERR_W-1:0]  out_err_r;
  logic signed [DUTY_W-1:0] out_left_r;
  logic signed [DUTY_W-1:0] out_right_r;

  logic                      in_acc;
  logic                      out_free;
  pos_t                      cl;
  pos_t                      cr;
  logic                      both_bar;
  logic signed [ERR_W-1:0]   tbl_err;
  logic                      run_same;
  logic                      run_chg;
  logic [RUN_COUNT_BITS-1:0] run_new;
  logic [RUN_COUNT_BITS-1:0] prior_len_new;
  logic signed [ERR_W-1:0]   prior_err_new;
  logic                      prior_vld_new;
  logic                      use_d_new;
  logic [DEN_W-1:0]          den_sum;
  logic [DEN_W-1:0]          den_new;
  logic signed [DE_W-1:0]    de_new;

  logic signed [GAIN_W+ERR_W:0] prod_p;
  logic signed [G_W-1:0]        prod_p_ext;
  logic [DE_W-1:0]              de_mag;
  logic [GAIN_W+DE_W-1:0]       prod_d;
  logic [DVD_W-1:0]             prod_d_ext;
  logic signed [G_W-1:0]        q_s;
  logic signed [G_W-1:0]        s_sum;
  logic signed [G_W-1:0]        g_val;
  logic                         frac;
  logic [DVD_W-1:0]             gmag_ext;
  logic signed [SUM_W-1:0]      nl_s;
  logic signed [SUM_W-1:0]      nr_s;
  logic signed [SUM_W-1:0]      gm_s;
  logic signed [SUM_W-1:0]      sl_s;
  logic signed [SUM_W-1:0]      left_raw;
  logic signed [SUM_W-1:0]      right_raw;

  logic             div_start;
  logic [DVD_W-1:0] div_dvd;
  logic [DEN_W-1:0] div_dvs;
  logic             div_done;
  logic [DVD_W-1:0] div_q;
  logic [DEN_W-1:0] div_rem;

  function automatic pos_t classify(
    input logic [CMP_W-1:0] s,
    input logic [CMP_W-1:0] tape_thr,
    input logic [CMP_W-1:0] bar_thr
  );
    pos_t p;
    if (s > bar_thr) p = POS_BAR;
    else if (s > tape_thr) p = POS_ON;
    else p = POS_OFF;
    return p;
  endfunction

  function automatic logic signed [DUTY_W-1:0] sat_duty(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] lim;
    logic signed [SUM_W-1:0] c;
    lim = $signed(SUM_W'(DUTY_MAX));
    if (v > lim) c = lim;
    else if (v < -lim) c = -lim;
    else c = v;
    return DUTY_W'(c);
  endfunction

  tfpd_div #(
    .DVD_BITS (DVD_W),
    .DVS_BITS (DEN_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  assign in_tready  = (st_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_bar_r;
  assign out_tdata  = {1'b0, out_right_r, out_left_r, out_err_r};

  always_comb begin
    cl = classify(CMP_W'(in_tdata[SAMPLE_BITS-1:0]), CMP_W'(tape_thr_r), CMP_W'(bar_thr_r));
    cr = classify(CMP_W'(in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]), CMP_W'(tape_thr_r),
                  CMP_W'(bar_thr_r));
    both_bar = (cl == POS_BAR) && (cr == POS_BAR);
    tbl_err  = table_error(cl, cr, last_lpos_r, last_rpos_r, last_err_r, last_vld_r,
                           lost_err_r);
    run_same = last_vld_r && (last_err_r == tbl_err);
    run_chg  = last_vld_r && (last_err_r != tbl_err);
    if (run_chg) run_new = RUN_COUNT_BITS'(1);
    else if (run_same && (run_len_r != '1)) run_new = run_len_r + 1'b1;
    else run_new = run_len_r;
    prior_len_new = run_chg ? run_len_r : prior_len_r;
    prior_err_new = run_chg ? last_err_r : prior_err_r;
    prior_vld_new = prior_vld_r || run_chg;
    use_d_new = prior_vld_new &&
                !((run_new > RUN_COUNT_BITS'(clear_run_r)) && (tbl_err == 0));
    den_sum = DEN_W'(prior_len_new) + DEN_W'(run_new) - 1'b1;
    den_new = (den_sum == '0) ? DEN_W'(1) : den_sum;
    de_new  = DE_W'(tbl_err) - DE_W'(prior_err_new);
  end

  always_comb begin
    prod_p     = err_r * $signed({1'b0, p_gain_r});
    prod_p_ext = G_W'(prod_p);
    de_mag     = de_r[DE_W-1] ? DE_W'(-de_r) : DE_W'(de_r);
    prod_d     = d_gain_r * de_mag;
    prod_d_ext = DVD_W'(prod_d);
    q_s   = use_d_r ? $signed(G_W'(div_q)) : '0;
    s_sum = a_r + (b_neg_r ? -q_s : q_s);
    frac  = use_d_r && (div_rem != '0);
    if (frac && b_neg_r && (s_sum > 0)) g_val = s_sum - 1'b1;
    else if (frac && !b_neg_r && (s_sum < 0)) g_val = s_sum + 1'b1;
    else g_val = s_sum;
    gmag_ext  = DVD_W'(gmag_r);
    nl_s      = $signed(SUM_W'(nom_left_r));
    nr_s      = $signed(SUM_W'(nom_right_r));
    gm_s      = $signed(SUM_W'(gmag_r));
    sl_s      = $signed(SUM_W'(div_q));
    left_raw  = g_neg_r ? (nl_s + gm_s) : (nl_s - sl_s);
    right_raw = g_neg_r ? (nr_s - sl_s) : (nr_s + gm_s);
  end

  always_comb begin
    st_nxt    = st_r;
    div_start = 1'b0;
    div_dvd   = bmag_r;
    div_dvs   = den_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_acc) st_nxt = both_bar ? S_OUT : S_MUL_P;
      end
      S_MUL_P: st_nxt = S_MUL_D;
      S_MUL_D: st_nxt = S_DIV1;
      S_DIV1: begin
        div_start = use_d_r;
        st_nxt    = use_d_r ? S_DIV1_W : S_SUM;
      end
      S_DIV1_W: begin
        if (div_done) st_nxt = S_SUM;
      end
      S_SUM: st_nxt = S_DIV2;
      S_DIV2: begin
        div_start = 1'b1;
        div_dvd   = (gmag_ext << 2) + (gmag_ext << 1);
        div_dvs   = DEN_W'(SLOW_DEN);
        st_nxt    = S_DIV2_W;
      end
      S_DIV2_W: begin
        if (div_done) st_nxt = S_DUTY;
      end
      S_DUTY: st_nxt = S_OUT;
      S_OUT: begin
        if (out_free) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_gain_r    <= '0;
      d_gain_r    <= '0;
      tape_thr_r  <= THR_W'(200);
      bar_thr_r   <= THR_W'(800);
      nom_left_r  <= NOM_W'(35000);
      nom_right_r <= NOM_W'(35000);
      clear_run_r <= CLR_W'(15);
      lost_err_r  <= LOST_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_P_GAIN:    p_gain_r    <= cfg_data[GAIN_W-1:0];
        REG_D_GAIN:    d_gain_r    <= cfg_data[GAIN_W-1:0];
        REG_TAPE_THR:  tape_thr_r  <= cfg_data[THR_W-1:0];
        REG_BAR_THR:   bar_thr_r   <= cfg_data[THR_W-1:0];
        REG_NOM_LEFT:  nom_left_r  <= cfg_data[NOM_W-1:0];
        REG_NOM_RIGHT: nom_right_r <= cfg_data[NOM_W-1:0];
        REG_CLEAR_RUN: clear_run_r <= cfg_data[CLR_W-1:0];
        REG_LOST_ERR:  lost_err_r  <= cfg_data[LOST_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_lpos_r  <= POS_OFF;
      last_rpos_r  <= POS_OFF;
      last_err_r   <= '0;
      last_vld_r   <= 1'b0;
      run_len_r    <= RUN_COUNT_BITS'(1);
      prior_len_r  <= '0;
      prior_vld_r  <= 1'b0;
      prior_err_r  <= '0;
      held_left_r  <= '0;
      held_right_r <= '0;
    end else begin
      if (in_acc && !both_bar) begin
        last_lpos_r <= cl;
        last_rpos_r <= cr;
        last_err_r  <= tbl_err;
        last_vld_r  <= 1'b1;
        run_len_r   <= run_new;
        prior_len_r <= prior_len_new;
        prior_vld_r <= prior_vld_new;
        prior_err_r <= prior_err_new;
      end
      if (st_r == S_DUTY) begin
        held_left_r  <= sat_duty(left_raw);
        held_right_r <= sat_duty(right_raw);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      bar_r   <= both_bar;
      err_r   <= tbl_err;
      de_r    <= de_new;
      use_d_r <= use_d_new;
      den_r   <= den_new;
    end
    if (st_r == S_MUL_P) begin
      a_r <= (prod_p_ext <<< 2) + prod_p_ext;
    end
    if (st_r == S_MUL_D) begin
      bmag_r  <= (prod_d_ext << 7) + (prod_d_ext << 4) + (prod_d_ext << 2) +
                 (prod_d_ext << 1);
      b_neg_r <= de_r[DE_W-1];
    end
    if (st_r == S_SUM) begin
      g_neg_r <= g_val[G_W-1];
      gmag_r  <= g_val[G_W-1] ? G_W'(-g_val) : G_W'(g_val);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (st_r == S_OUT && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_OUT && out_free) begin
      out_bar_r   <= bar_r;
      out_err_r   <= last_err_r;
      out_left_r  <= held_left_r;
      out_right_r <= held_right_r;
    end
  end

endmodule

// File: design/tfpd_div.sv
// Restoring serial divider that produces one quotient bit per cycle.
module tfpd_div
  import tfpd_pkg::*;
#(
  parameter int DVD_BITS = DVD_W,
  parameter int DVS_BITS = RUN_COUNT_BITS_DEF + 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DVD_BITS-1:0] dividend,
  input  logic [DVS_BITS-1:0] divisor,
  output logic                done,
  output logic [DVD_BITS-1:0] quotient,
  output logic [DVS_BITS-1:0] remainder
);

  localparam int CNT_W = $clog2(DVD_BITS + 1);

  logic                busy_r;
  logic                done_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [DVD_BITS-1:0] dvd_r;
  logic [DVS_BITS-1:0] dvs_r;
  logic [DVS_BITS-1:0] rem_r;
  logic [DVS_BITS:0]   rem_sh;
  logic [DVS_BITS:0]   rem_diff;
  logic                q_bit;

  always_comb begin
    rem_sh   = {rem_r, dvd_r[DVD_BITS-1]};
    rem_diff = rem_sh - {1'b0, dvs_r};
    q_bit    = (rem_sh >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(DVD_BITS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_BITS-2:0], q_bit};
      rem_r <= q_bit ? rem_diff[DVS_BITS-1:0] : rem_sh[DVS_BITS-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule

// File: test/tape_follow_pd_steering_tb.sv
// Self-checking testbench for the tape follower steering block: sensor pairs in, checked wheel duties out.
module tape_follow_pd_steering_tb
  import tfpd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 7;
  localparam int QUIET_LIMIT  = 3000;
  localparam int IDLE_PCT     = 18;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 100;
  localparam int MAX_REPORTS  = 10;
  localparam int SAMPLE_MAX   = 1023;
  localparam int DUTY_LIM     = 65535;
  localparam int RUN_MAX      = 65535;

  typedef struct packed {
    logic [9:0] right;
    logic [9:0] left;
  } sample_pair_t;

  typedef struct packed {
    logic               at_bar;
    logic signed [4:0]  err;
    logic signed [16:0] left;
    logic signed [16:0] right;
  } steer_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [23:0]           in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic                  out_tuser;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  tape_follow_pd_steering i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Register copy and tracking state of the predictor.
  logic [9:0]         kp, kd, tape_thr, bar_thr;
  logic [15:0]        nom_l, nom_r;
  logic [7:0]         clear_run;
  logic [3:0]         lost_mag;
  pos_t               prev_l, prev_r;
  logic signed [4:0]  err_q, prior_err;
  logic               err_known, prior_known;
  int unsigned        run_len, prior_len;
  logic signed [16:0] hold_l, hold_r;

  sample_pair_t  item_q[$];
  steer_result_t expect_q[$];
  int            n_queued = 0;
  int            n_in     = 0;
  int            n_out    = 0;
  int            n_bar    = 0;
  int            fails    = 0;
  int            n_settings = 0;
  int            quiet    = 0;
  logic          in_fire  = 1'b0;
  logic          calm;
  bit            hold_req  = 1'b0;
  bit            hold_done = 1'b0;
  int            hold_left = 0;

  pos_t walk_l [4] = '{POS_ON, POS_ON, POS_OFF, POS_OFF};
  pos_t walk_r [4] = '{POS_OFF, POS_ON, POS_ON, POS_OFF};

  assign calm = (n_in >= 500) && (n_in < 700);

  function automatic void model_reset();
    kp = '0; kd = '0; tape_thr = 10'd200; bar_thr = 10'd800;
    nom_l = 16'd35000; nom_r = 16'd35000; clear_run = 8'd15; lost_mag = 4'd8;
    prev_l = POS_OFF; prev_r = POS_OFF;
    err_q = '0; err_known = 1'b0;
    run_len = 1; prior_len = 0; prior_known = 1'b0; prior_err = '0;
    hold_l = '0; hold_r = '0;
  endfunction

  function automatic pos_t sort_sample(logic [9:0] s);
    if (s > bar_thr) return POS_BAR;
    if (s > tape_thr) return POS_ON;
    return POS_OFF;
  endfunction

  // Cells that the position table leaves open keep the stored error.
  function automatic logic signed [4:0] lookup_error(pos_t cl, pos_t cr, pos_t pl, pos_t pr);
    logic              was_neg;
    logic              was_pos;
    int                lost_i;
    logic signed [4:0] e;
    was_neg = err_known && (err_q < 0);
    was_pos = !err_known || (err_q > 0);
    lost_i  = lost_mag;
    e       = err_q;
    if (cl == POS_ON && cr == POS_ON) begin
      if (pl == POS_ON && pr == POS_ON) e = 0;
      else if (pl == POS_OFF && pr == POS_ON) e = -2;
      else if (pl == POS_ON && pr == POS_OFF) e = 2;
      else if (pl == POS_OFF && pr == POS_OFF && (was_pos || was_neg)) e = was_pos ? 1 : -1;
    end else if (cl == POS_OFF && cr == POS_ON) begin
      if (pl == POS_ON && pr == POS_ON) e = -2;
      else if (pl == POS_OFF && pr == POS_ON) e = -3;
      else if (pl == POS_OFF && pr == POS_OFF) e = -4;
    end else if (cl == POS_ON && cr == POS_OFF) begin
      if (pl == POS_ON && pr == POS_ON) e = 2;
      else if (pl == POS_ON && pr == POS_OFF) e = 3;
      else if (pl == POS_OFF && pr == POS_OFF) e = 4;
    end else if (cl == POS_OFF && cr == POS_OFF) begin
      if (pl == POS_OFF && pr == POS_ON) e = -5;
      else if (pl == POS_ON && pr == POS_OFF) e = 5;
      else if (pl == POS_OFF && pr == POS_OFF) e = was_neg ? -lost_i : lost_i;
    end
    return e;
  endfunction

  function automatic logic signed [16:0] duty_clip(longint v);
    if (v > DUTY_LIM) return DUTY_LIM;
    if (v < -DUTY_LIM) return -DUTY_LIM;
    return v;
  endfunction

  function automatic steer_result_t steer_predict(logic [9:0] ls, logic [9:0] rs);
    steer_result_t     res;
    pos_t              cl, cr;
    logic signed [4:0] e;
    longint            num, den, g, slow, l, r, e_l, pe_l, kp_l, kd_l, nl_l, nr_l;
    cl = sort_sample(ls);
    cr = sort_sample(rs);
    if (cl == POS_BAR && cr == POS_BAR) begin
      res.at_bar = 1'b1;
      res.err    = err_q;
      res.left   = hold_l;
      res.right  = hold_r;
      return res;
    end
    e = lookup_error(cl, cr, prev_l, prev_r);
    prev_l = cl;
    prev_r = cr;
    if (err_known) begin
      if (err_q == e) begin
        if (run_len < RUN_MAX) run_len++;
      end else begin
        prior_len   = run_len;
        prior_err   = err_q;
        prior_known = 1'b1;
        run_len     = 1;
      end
    end
    e_l  = e;
    pe_l = prior_err;
    kp_l = kp;
    kd_l = kd;
    nl_l = nom_l;
    nr_l = nom_r;
    den  = 1;
    num  = 0;
    if (prior_known && !(run_len > clear_run && e == 0)) begin
      den = longint'(prior_len) + longint'(run_len) - 1;
      if (den < 1) den = 1;
      num = 150 * kd_l * (e_l - pe_l);
    end
    num = num + 5 * e_l * kp_l * den;
    g   = num / den;
    err_q     = e;
    err_known = 1'b1;
    slow = (g * 6) / 5;
    if (g > 0) begin
      r = nr_l + g;
      l = nl_l - slow;
    end else if (g < 0) begin
      l = nl_l - g;
      r = nr_l + slow;
    end else begin
      l = nl_l;
      r = nr_l;
    end
    hold_l     = duty_clip(l);
    hold_r     = duty_clip(r);
    res.at_bar = 1'b0;
    res.err    = e;
    res.left   = hold_l;
    res.right  = hold_r;
    return res;
  endfunction

  function automatic logic [9:0] sample_in(pos_t p);
    int lo, hi;
    case (p)
      POS_OFF: begin
        lo = 0;
        hi = (tape_thr < bar_thr) ? tape_thr : bar_thr;
      end
      POS_ON: begin
        lo = tape_thr + 1;
        hi = bar_thr;
      end
      default: begin
        lo = bar_thr + 1;
        hi = SAMPLE_MAX;
      end
    endcase
    if (lo > hi) return $urandom_range(SAMPLE_MAX);
    case ($urandom_range(7))
      0: return lo;
      1: return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  task automatic send(logic [9:0] ls, logic [9:0] rs);
    sample_pair_t sp;
    sp.left  = ls;
    sp.right = rs;
    item_q.push_back(sp);
    n_queued++;
  endtask

  // Mostly the tape drifting under the sensors, with runs and bar crossings,
  // the rest malformed position pairs and raw noise.
  task automatic add_track(int count);
    int stop, k, reps, pick;
    stop = n_queued + count;
    k    = 1;
    while (n_queued < stop) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        send($urandom_range(SAMPLE_MAX), $urandom_range(SAMPLE_MAX));
      end else if (pick < 22) begin
        reps = $urandom_range(2, 1);
        repeat (reps) send(sample_in(pos_t'($urandom_range(2))), sample_in(pos_t'($urandom_range(2))));
      end else begin
        k = (k + $urandom_range(2) + 3) % 4;
        if (k == 1 && $urandom_range(3) == 0) reps = $urandom_range(40, 15);
        else reps = $urandom_range(5, 1);
        repeat (reps) begin
          if ($urandom_range(29) == 0) send(sample_in(POS_BAR), sample_in(POS_BAR));
          send(sample_in(walk_l[k]), sample_in(walk_r[k]));
        end
      end
    end
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    logic [15:0] mask;
    logic [15:0] word;
    case (idx)
      REG_NOM_LEFT, REG_NOM_RIGHT: mask = 16'hFFFF;
      REG_CLEAR_RUN:               mask = 16'h00FF;
      REG_LOST_ERR:                mask = 16'h000F;
      default:                     mask = 16'h03FF;
    endcase
    // Bits above the register width carry junk and must be ignored.
    word = (val[15:0] & mask) | (16'($urandom) & ~mask);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_P_GAIN:    kp        = word[9:0];
      REG_D_GAIN:    kd        = word[9:0];
      REG_TAPE_THR:  tape_thr  = word[9:0];
      REG_BAR_THR:   bar_thr   = word[9:0];
      REG_NOM_LEFT:  nom_l     = word;
      REG_NOM_RIGHT: nom_r     = word;
      REG_CLEAR_RUN: clear_run = word[7:0];
      default:       lost_mag  = word[3:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(int unsigned p, int unsigned d, int unsigned tape,
                               int unsigned bar, int unsigned nl, int unsigned nr,
                               int unsigned clr, int unsigned lost);
    cfg_write(REG_P_GAIN, p);
    cfg_write(REG_D_GAIN, d);
    cfg_write(REG_TAPE_THR, tape);
    cfg_write(REG_BAR_THR, bar);
    cfg_write(REG_NOM_LEFT, nl);
    cfg_write(REG_NOM_RIGHT, nr);
    cfg_write(REG_CLEAR_RUN, clr);
    cfg_write(REG_LOST_ERR, lost);
    n_settings++;
    @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    while (n_out < n_queued) @(negedge clk);
  endtask

  always @(negedge clk) begin
    sample_pair_t nxt;
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (item_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        nxt = item_q.pop_front();
        in_tdata  <= {4'b0, nxt};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    steer_result_t got, want;
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      got.at_bar = out_tuser;
      got.err    = out_tdata[4:0];
      got.left   = out_tdata[21:5];
      got.right  = out_tdata[38:22];
      n_out <= n_out + 1;
      if (got.at_bar) n_bar++;
      if (expect_q.size() == 0) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $display("Result %0d arrived with nothing expected: bar=%0d err=%0d left=%0d right=%0d",
                   n_out, got.at_bar, got.err, got.left, got.right);
      end else begin
        want = expect_q.pop_front();
        if (got !== want) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("Result %0d: expected bar=%0d err=%0d left=%0d right=%0d, got bar=%0d err=%0d left=%0d right=%0d",
                     n_out, want.at_bar, want.err, want.left, want.right,
                     got.at_bar, got.err, got.left, got.right);
        end
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      expect_q.push_back(steer_predict(in_tdata[9:0], in_tdata[19:10]));
      n_in <= n_in + 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("No transfer for %0d cycles, %0d of %0d results received", quiet, n_out, n_queued);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int unsigned t;
    model_reset();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: held duties of zero at the bar, the unset error sign,
    // threshold equality, open table cells and a zero error kept across loss.
    send(1023, 1023);
    send(500, 500);
    send(500, 500);
    send(201, 200);
    send(800, 0);
    send(0, 0);
    send(0, 0);
    send(0, 500);
    send(0, 800);
    send(800, 800);
    send(0, 1023);
    send(0, 0);
    send(0, 0);
    send(500, 500);
    send(1023, 1023);
    send(801, 801);
    send(500, 500);
    send(0, 0);
    send(500, 500);
    send(0, 500);
    send(500, 0);
    send(0, 0);
    drain();

    apply_setting(1023, 1023, 200, 800, 65535, 0, 0, 15);
    add_track(230);
    drain();

    apply_setting(0, 1023, 0, 1023, 0, 65535, 255, 0);
    add_track(230);
    drain();

    apply_setting(40, 25, 200, 800, 35000, 35000, 15, 8);
    add_track(250);
    @(posedge clk);
    hold_req = 1'b1;
    drain();

    t = $urandom_range(600, 20);
    apply_setting($urandom_range(1023), $urandom_range(1023), t, $urandom_range(1023, t + 1),
                  $urandom_range(65535), $urandom_range(65535), $urandom_range(255),
                  $urandom_range(15));
    add_track(250);
    drain();

    apply_setting($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                  $urandom_range(1023), $urandom_range(65535), $urandom_range(65535),
                  $urandom_range(255), $urandom_range(15));
    add_track(250);
    drain();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (expect_q.size() != 0) begin
      fails++;
      $display("%0d expected results never arrived", expect_q.size());
    end
    $display("Sent %0d sensor pairs under %0d register settings after the reset values.",
             n_in, n_settings);
    $display("Checked %0d results, %0d of them at the bar, with %0d mismatches.",
             n_out, n_bar, fails);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
